// File: rtl/amo_pkg.sv
// amo_pkg: shared types, register indexes, constants and small helper
// functions for the anchored month offset block.
// No dependencies.
package amo_pkg;

   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int STEP_W     = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = STEP_W;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_OFFSET_UNIT  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DAY_OPTION   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ANCHOR_MONTH = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP_COUNT   = 2'd3;

   // period kinds
   localparam logic [1:0] UNIT_MONTH   = 2'd0;
   localparam logic [1:0] UNIT_QUARTER = 2'd1;
   localparam logic [1:0] UNIT_YEAR    = 2'd2;

   localparam logic [1:0]            RST_OFFSET_UNIT  = UNIT_MONTH;
   localparam logic                  RST_DAY_OPTION   = 1'b0;
   localparam logic [MONTH_W-1:0]    RST_ANCHOR_MONTH = 4'd3;
   localparam logic [STEP_W-1:0]     RST_STEP_COUNT   = 11'd1;

   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

   // bias in years that keeps the month total non-negative before the divide
   localparam int DIV_BIAS_YEARS  = 1100;
   localparam int DIV_BIAS_MONTHS = DIV_BIAS_YEARS * 12;

   // reciprocals: x/3 exact for x < 2**15, x/25 exact for x < 2**14
   localparam logic [15:0] RECIP3  = 16'd21846;
   localparam int          RECIP3_SHIFT = 16;
   localparam logic [14:0] RECIP25 = 15'd20972;
   localparam int          RECIP25_SHIFT = 19;

   typedef struct packed {
      logic [YEAR_W-1:0]  in_year;
      logic [MONTH_W-1:0] in_month;
      logic [DAY_W-1:0]   in_day;
   } amo_req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  out_year;
      logic [MONTH_W-1:0] out_month;
      logic [DAY_W-1:0]   out_day;
      logic               out_of_range;
   } amo_rsp_type;

   // month length, months outside 1..12 count as 31 days
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

   function automatic logic [1:0] mod3(input logic [MONTH_W-1:0] v);
      logic [MONTH_W-1:0] r;
      r = v;
      if (r >= 4'd12) r = r - 4'd12;
      if (r >= 4'd6) r = r - 4'd6;
      if (r >= 4'd3) r = r - 4'd3;
      return r[1:0];
   endfunction

endpackage

// File: rtl/amo_leap.sv
// amo_leap: gregorian leap year test on a 14-bit year.
// Depends on amo_pkg; divisibility by 25 goes through a reciprocal multiply.
module amo_leap (
   input  logic [amo_pkg::YEAR_W-1:0] year,
   output logic                       leap
);
   import amo_pkg::*;

   logic [YEAR_W+15-1:0] prod;
   logic [9:0]           quot;
   logic [YEAR_W-1:0]    back;
   logic                 by25;

   assign prod = (YEAR_W+15)'(year) * (YEAR_W+15)'(RECIP25);
   assign quot = prod[RECIP25_SHIFT +: 10];
   // quot * 25 by shift and add
   assign back = YEAR_W'({quot, 4'b0000}) + YEAR_W'({quot, 3'b000}) + YEAR_W'(quot);
   assign by25 = (back == year);

   // divisible by 4 but not 100, or divisible by 400
   assign leap = ((year[1:0] == 2'b00) && !by25) || ((year[3:0] == 4'b0000) && by25);

endmodule

// File: rtl/anchored_month_offset.sv
// anchored_month_offset: moves a date by month, quarter or year periods to
// the first or last day of the target month. Top level of the block.
// Depends on amo_pkg and amo_leap.
//
// Usage:
//   An item (year, month, day) is taken on req_data at a clock edge where
//   start is high and busy is low. busy is only high during reset, so one
//   item can enter every cycle and several are in flight at once.
//   The result shows on rsp_data with rsp_valid high for exactly one cycle,
//   after the input register, roll and month total, divide by 12, year
//   shift and saturation and day lookup registers, in that order.
//   Throughput is one item per cycle; the result register ahead of the
//   receiver is the only place a result waits, and the receiver cannot
//   stall, so no result is ever held or dropped.
//   Configuration (unit, day option, anchor month, step count) is written
//   through csr_we / csr_addr / csr_wdata with no wait; the user must write
//   it only while no item is in flight, as the block does not enforce this.
//   Synchronous reset clears all valid bits and loads the register reset
//   values (month unit, first day, anchor March, step one).
module anchored_month_offset (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  amo_pkg::amo_req_type           req_data,
   output logic                           rsp_valid,
   output amo_pkg::amo_rsp_type           rsp_data,
   input  logic                           csr_we,
   input  logic [amo_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [amo_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import amo_pkg::*;

   // configuration
   logic [1:0]               unit_ff;
   logic                     dayopt_ff;
   logic [MONTH_W-1:0]       anchor_ff;
   logic signed [STEP_W-1:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff   <= RST_OFFSET_UNIT;
         dayopt_ff <= RST_DAY_OPTION;
         anchor_ff <= RST_ANCHOR_MONTH;
         step_ff   <= RST_STEP_COUNT;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_OFFSET_UNIT: begin
               unit_ff <= csr_wdata[1:0];
            end
            REG_DAY_OPTION: begin
               dayopt_ff <= csr_wdata[0];
            end
            REG_ANCHOR_MONTH: begin
               anchor_ff <= csr_wdata[MONTH_W-1:0];
            end
            REG_STEP_COUNT: begin
               step_ff <= csr_wdata[STEP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // stage 1: input register with leap flag of the input year
   logic              in_leap;
   logic              s1_valid_ff;
   amo_req_type       s1_req_ff;
   logic              s1_leap_ff;

   amo_leap u_leap_in (
      .year (req_data.in_year),
      .leap (in_leap)
   );

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      s1_req_ff  <= req_data;
      s1_leap_ff <= in_leap;
   end

   // stage 2: roll the count and form the zero-based month total
   logic [DAY_W-1:0]         cmp_day;
   logic signed [5:0]        since;
   logic signed [STEP_W:0]   n_roll;
   logic signed [14:0]       n_wide;
   logic signed [14:0]       since_wide;
   logic signed [14:0]       months;
   logic signed [15:0]       total_in;
   logic                     s2_valid_ff;
   logic signed [15:0]       total_ff;
   logic [YEAR_W-1:0]        s2_year_ff;

   always_comb begin
      cmp_day = dayopt_ff ? month_len(s1_req_ff.in_month, s1_leap_ff) : 5'd1;
      unique case (unit_ff)
         UNIT_QUARTER: begin
            since = $signed({4'b0000, mod3(s1_req_ff.in_month)})
                  - $signed({4'b0000, mod3(anchor_ff)});
         end
         UNIT_YEAR: begin
            since = $signed({2'b00, s1_req_ff.in_month}) - $signed({2'b00, anchor_ff});
         end
         default: begin
            since = 6'sd0;
         end
      endcase
      // month mode is the same roll with the period offset at zero
      n_roll = {step_ff[STEP_W-1], step_ff};
      if (step_ff > 0) begin
         if (since < 0 || (since == 0 && s1_req_ff.in_day < cmp_day)) n_roll = n_roll - 12'sd1;
      end else begin
         if (since > 0 || (since == 0 && s1_req_ff.in_day > cmp_day)) n_roll = n_roll + 12'sd1;
      end
      n_wide     = 15'(n_roll);
      since_wide = 15'(since);
      unique case (unit_ff)
         UNIT_QUARTER: begin
            months = n_wide + (n_wide <<< 1) - since_wide;
         end
         UNIT_YEAR: begin
            months = (n_wide <<< 3) + (n_wide <<< 2) - since_wide;
         end
         default: begin
            months = n_wide;
         end
      endcase
      total_in = 16'(months) + $signed({12'd0, s1_req_ff.in_month}) - 16'sd1;
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      total_ff   <= total_in;
      s2_year_ff <= s1_req_ff.in_year;
   end

   // stage 3: floor divide by 12 on the biased total, as (u / 4) / 3
   logic [14:0]        biased;
   logic [27:0]        prod3;
   logic [11:0]        quot_in;
   logic               s3_valid_ff;
   logic [14:0]        biased_ff;
   logic [11:0]        quot_ff;
   logic [YEAR_W-1:0]  s3_year_ff;

   assign biased  = 15'(total_ff + 16'(DIV_BIAS_MONTHS));
   assign prod3   = 28'(biased[14:2]) * 28'(RECIP3);
   assign quot_in = prod3[RECIP3_SHIFT +: 12];

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      biased_ff  <= biased;
      quot_ff    <= quot_in;
      s3_year_ff <= s2_year_ff;
   end

   // stage 4: remainder, year shift and saturation
   logic [14:0]          rem_wide;
   logic signed [15:0]   new_year;
   logic [YEAR_W-1:0]    year_in;
   logic                 flag_in;
   logic                 s4_valid_ff;
   logic [YEAR_W-1:0]    s4_year_ff;
   logic [MONTH_W-1:0]   s4_month_ff;
   logic                 s4_flag_ff;

   always_comb begin
      rem_wide = biased_ff - (15'({quot_ff, 3'b000}) + 15'({quot_ff, 2'b00}));
      new_year = $signed({2'b00, s3_year_ff}) + $signed({4'b0000, quot_ff})
               - 16'(DIV_BIAS_YEARS);
      priority if (new_year < 0) begin
         year_in = '0;
         flag_in = 1'b1;
      end else if (new_year > $signed({2'b00, YEAR_MAX})) begin
         year_in = YEAR_MAX;
         flag_in = 1'b1;
      end else begin
         year_in = new_year[YEAR_W-1:0];
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else       s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      s4_year_ff  <= year_in;
      s4_month_ff <= rem_wide[MONTH_W-1:0] + 4'd1;
      s4_flag_ff  <= flag_in;
   end

   // stage 5: day of the result month into the result register
   logic        out_leap;
   logic        rsp_valid_ff;
   amo_rsp_type rsp_in;
   amo_rsp_type rsp_ff;

   amo_leap u_leap_out (
      .year (s4_year_ff),
      .leap (out_leap)
   );

   always_comb begin
      rsp_in.out_year     = s4_year_ff;
      rsp_in.out_month    = s4_month_ff;
      rsp_in.out_day      = dayopt_ff ? month_len(s4_month_ff, out_leap) : 5'd1;
      rsp_in.out_of_range = s4_flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result without an item five cycles earlier");

   a_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_month >= 4'd1 && rsp_data.out_month <= 4'd12))
      else $error("result month outside 1..12");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range)
         |-> (rsp_data.out_year == '0 || rsp_data.out_year == YEAR_MAX))
      else $error("flagged year not saturated");

endmodule

// File: tb/sv/anchored_month_offset_tb.sv
// anchored_month_offset_tb: self-checking bench for the date offset block.
// Runs a directed table and then random dates under many register settings.
// Depends on amo_pkg and the anchored_month_offset rtl.
`timescale 1ns / 100ps

module anchored_month_offset_tb;
   import amo_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 700;
   localparam int ERROR_PRINTS = 40;

   typedef struct {
      logic [1:0]  unit;
      logic        last_day;
      logic [3:0]  anchor;
      int          step;
      amo_req_type date;
      bit          typed;
      amo_rsp_type want;
   } vector_row_type;

   typedef struct {
      amo_rsp_type rsp;
      int          id;
   } expected_date_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   amo_req_type           req_data;
   logic                  rsp_valid;
   amo_rsp_type           rsp_data;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // copy of the block's registers, updated from the write port
   logic [1:0]            cfg_unit;
   logic                  cfg_last_day;
   logic [3:0]            cfg_anchor;
   logic signed [10:0]    cfg_step;

   expected_date_type     expected_dates[$];
   vector_row_type        directed_rows[$];
   int                    errors = 0;
   int                    stall_cycles = 0;
   int                    item_id = 0;

   anchored_month_offset uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int month_days(input int y, input int m);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         2: begin
            return leap ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   // quarter and year modes: an off-anchor date counts its own anchor as one step
   function automatic int roll_count(input int n, input int since, input int day,
                                     input int mark);
      if (n > 0) begin
         if (since < 0 || (since == 0 && day < mark)) n = n - 1;
      end else begin
         if (since > 0 || (since == 0 && day > mark)) n = n + 1;
      end
      return n;
   endfunction

   function automatic amo_rsp_type shift_to_anchor(input amo_req_type d);
      int y, m, day, a, n, mark, since, months, t, q, r, ny, nm;
      amo_rsp_type res;
      y = d.in_year;
      m = d.in_month;
      day = d.in_day;
      a = cfg_anchor;
      n = cfg_step;
      mark = cfg_last_day ? month_days(y, m) : 1;
      case (cfg_unit)
         UNIT_QUARTER: begin
            since = (m % 3) - (a % 3);
            months = roll_count(n, since, day, mark) * 3 - since;
         end
         UNIT_YEAR: begin
            since = m - a;
            months = roll_count(n, since, day, mark) * 12 + a - m;
         end
         default: begin
            if (n > 0 && day < mark) n = n - 1;
            else if (n <= 0 && day > mark) n = n + 1;
            months = n;
         end
      endcase
      t = m + months - 1;
      q = t / 12;
      r = t % 12;
      if (r < 0) begin
         r = r + 12;
         q = q - 1;
      end
      ny = y + q;
      nm = r + 1;
      res.out_of_range = 1'b0;
      if (ny < 0) begin
         ny = 0;
         res.out_of_range = 1'b1;
      end else if (ny > 9999) begin
         ny = 9999;
         res.out_of_range = 1'b1;
      end
      res.out_year  = ny[YEAR_W-1:0];
      res.out_month = nm[MONTH_W-1:0];
      res.out_day   = cfg_last_day ? DAY_W'(month_days(ny, nm)) : 5'd1;
      return res;
   endfunction

   function automatic amo_req_type random_date();
      amo_req_type d;
      int k, y, m, len;
      k = $urandom_range(0, 99);
      if (k < 8) y = $urandom_range(10000, 16383);
      else if (k < 16) y = $urandom_range(0, 3);
      else if (k < 24) y = $urandom_range(9990, 9999);
      else y = $urandom_range(0, 9999);
      m = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      len = month_days(y, m);
      k = $urandom_range(0, 99);
      d.in_year  = y[YEAR_W-1:0];
      d.in_month = m[MONTH_W-1:0];
      if (k < 30) d.in_day = 5'd1;
      else if (k < 60) d.in_day = len[DAY_W-1:0];
      else if (k < 90) d.in_day = DAY_W'($urandom_range(1, len));
      else d.in_day = DAY_W'($urandom_range(0, 31));
      return d;
   endfunction

   task automatic report_mismatch(input string msg);
      if (errors < ERROR_PRINTS) $display("ERROR at %0t: %s", $realtime, msg);
      errors = errors + 1;
   endtask

   task automatic add_row(input logic [1:0] u, input int last, input int a,
                          input int s, input int y, input int m, input int d,
                          input bit typed, input int ey, input int em, input int ed,
                          input int eflag);
      vector_row_type row;
      row.unit = u;
      row.last_day = last[0];
      row.anchor = a[3:0];
      row.step = s;
      row.date.in_year = y[YEAR_W-1:0];
      row.date.in_month = m[MONTH_W-1:0];
      row.date.in_day = d[DAY_W-1:0];
      row.typed = typed;
      row.want.out_year = ey[YEAR_W-1:0];
      row.want.out_month = em[MONTH_W-1:0];
      row.want.out_day = ed[DAY_W-1:0];
      row.want.out_of_range = eflag[0];
      directed_rows.push_back(row);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_date(input amo_req_type d, input bit typed, input amo_rsp_type want);
      expected_date_type e;
      start = 1'b1;
      req_data = d;
      @(posedge clock);
      while (busy) @(posedge clock);
      e.rsp = typed ? want : shift_to_anchor(d);
      e.id = item_id;
      expected_dates.push_back(e);
      item_id = item_id + 1;
      @(negedge clock);
   endtask

   task automatic maybe_idle(input bit quiet);
      if (!quiet && $urandom_range(0, 99) < 13) begin
         start = 1'b0;
         req_data = $bits(amo_req_type)'($urandom);
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (expected_dates.size() != 0) @(negedge clock);
   endtask

   // unused upper data bits carry noise, the block keeps only the register width
   task automatic apply_settings(input logic [1:0] u, input logic last, input logic [3:0] a,
                                 input int s);
      logic [10:0] junk;
      wait_drained();
      junk = 11'($urandom);
      csr_we = 1'b1;
      csr_addr = REG_OFFSET_UNIT;
      csr_wdata = {junk[10:2], u};
      @(negedge clock);
      csr_addr = REG_DAY_OPTION;
      csr_wdata = {junk[10:1], last};
      @(negedge clock);
      csr_addr = REG_ANCHOR_MONTH;
      csr_wdata = {junk[10:4], a};
      @(negedge clock);
      csr_addr = REG_STEP_COUNT;
      csr_wdata = s[10:0];
      @(negedge clock);
      csr_we = 1'b0;
      csr_addr = CSR_ADDR_W'($urandom);
      csr_wdata = CSR_DATA_W'($urandom);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_unit <= RST_OFFSET_UNIT;
         cfg_last_day <= RST_DAY_OPTION;
         cfg_anchor <= RST_ANCHOR_MONTH;
         cfg_step <= RST_STEP_COUNT;
      end else if (csr_we) begin
         case (csr_addr)
            REG_OFFSET_UNIT: cfg_unit <= csr_wdata[1:0];
            REG_DAY_OPTION: cfg_last_day <= csr_wdata[0];
            REG_ANCHOR_MONTH: cfg_anchor <= csr_wdata[3:0];
            default: cfg_step <= csr_wdata;
         endcase
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      expected_date_type e;
      if (!reset && rsp_valid) begin
         if (expected_dates.size() == 0) begin
            report_mismatch($sformatf("result %0d-%0d-%0d with nothing expected",
                                      rsp_data.out_year, rsp_data.out_month, rsp_data.out_day));
         end else begin
            e = expected_dates.pop_front();
            if (rsp_data.out_year !== e.rsp.out_year)
               report_mismatch($sformatf("item %0d out_year %0d, want %0d",
                                         e.id, rsp_data.out_year, e.rsp.out_year));
            if (rsp_data.out_month !== e.rsp.out_month)
               report_mismatch($sformatf("item %0d out_month %0d, want %0d",
                                         e.id, rsp_data.out_month, e.rsp.out_month));
            if (rsp_data.out_day !== e.rsp.out_day)
               report_mismatch($sformatf("item %0d out_day %0d, want %0d",
                                         e.id, rsp_data.out_day, e.rsp.out_day));
            if (rsp_data.out_of_range !== e.rsp.out_of_range)
               report_mismatch($sformatf("item %0d out_of_range %0b, want %0b",
                                         e.id, rsp_data.out_of_range, e.rsp.out_of_range));
         end
      end
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d items outstanding",
                     stall_cycles, expected_dates.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      vector_row_type row;
      amo_rsp_type none;
      logic [1:0] u;
      logic last;
      logic [3:0] a;
      int s, k, i, phase, burst, sent;
      bit quiet;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      none = '0;

      // unit, last day, anchor, step, date, typed, expected date and flag
      add_row(UNIT_MONTH, 0, 3, 1, 2020, 1, 15, 1, 2020, 2, 1, 0);
      add_row(UNIT_MONTH, 0, 3, 1, 2020, 1, 1, 1, 2020, 2, 1, 0);
      add_row(UNIT_MONTH, 0, 3, 1, 9999, 12, 15, 1, 9999, 1, 1, 1);
      add_row(UNIT_MONTH, 0, 3, 1, 0, 1, 1, 0, 0, 0, 0, 0);
      add_row(UNIT_MONTH, 0, 3, -1024, 0, 1, 1, 1, 0, 9, 1, 1);
      add_row(UNIT_MONTH, 0, 3, -1024, 9999, 12, 31, 0, 0, 0, 0, 0);
      add_row(UNIT_MONTH, 0, 3, 1023, 9999, 12, 31, 1, 9999, 3, 1, 1);
      add_row(UNIT_MONTH, 0, 3, 0, 2021, 3, 1, 0, 0, 0, 0, 0);
      add_row(UNIT_MONTH, 0, 3, 0, 2021, 3, 2, 0, 0, 0, 0, 0);
      add_row(UNIT_MONTH, 1, 3, 1, 2024, 1, 31, 1, 2024, 2, 29, 0);
      add_row(UNIT_MONTH, 1, 3, 1, 1900, 1, 15, 0, 0, 0, 0, 0);
      add_row(UNIT_MONTH, 1, 3, 1, 2000, 1, 31, 0, 0, 0, 0, 0);
      add_row(UNIT_QUARTER, 0, 1, 1, 2021, 2, 15, 0, 0, 0, 0, 0);
      add_row(UNIT_QUARTER, 0, 1, 1, 2021, 1, 1, 0, 0, 0, 0, 0);
      add_row(UNIT_QUARTER, 1, 3, -1, 2021, 3, 31, 0, 0, 0, 0, 0);
      add_row(UNIT_QUARTER, 1, 3, -1, 2021, 5, 10, 0, 0, 0, 0, 0);
      add_row(UNIT_YEAR, 1, 12, 2, 2021, 6, 15, 0, 0, 0, 0, 0);
      add_row(UNIT_YEAR, 0, 12, 0, 2021, 12, 1, 0, 0, 0, 0, 0);
      // unit selector three behaves as month mode
      add_row(2'd3, 0, 3, 5, 2021, 11, 20, 0, 0, 0, 0, 0);
      // anchor months outside the calendar
      add_row(UNIT_QUARTER, 0, 0, 2, 2021, 7, 4, 0, 0, 0, 0, 0);
      add_row(UNIT_YEAR, 1, 15, -3, 2021, 8, 8, 0, 0, 0, 0, 0);
      // input month and day outside their ranges, year beyond 9999
      add_row(UNIT_MONTH, 1, 3, 1, 2021, 13, 31, 0, 0, 0, 0, 0);
      add_row(UNIT_YEAR, 0, 3, 1, 2021, 0, 0, 0, 0, 0, 0, 0);
      add_row(UNIT_MONTH, 1, 3, -1, 2021, 2, 30, 0, 0, 0, 0, 0);
      add_row(UNIT_MONTH, 0, 3, -1, 16383, 15, 31, 0, 0, 0, 0, 0);

      repeat (8) @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.unit !== cfg_unit || row.last_day !== cfg_last_day ||
             row.anchor !== cfg_anchor || row.step[10:0] !== cfg_step)
            apply_settings(row.unit, row.last_day, row.anchor, row.step);
         send_date(row.date, row.typed, row.want);
         maybe_idle(1'b0);
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         k = $urandom_range(0, 99);
         u = (k < 90) ? 2'($urandom_range(0, 2)) : 2'd3;
         last = 1'($urandom_range(0, 1));
         k = $urandom_range(0, 3);
         a = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 12))
                                           : ((k == 0) ? 4'd0 : 4'(12 + k));
         k = $urandom_range(0, 99);
         if (phase == 0) s = -1024;
         else if (phase == 1) s = 1023;
         else if (k < 40) s = int'($urandom_range(0, 8)) - 4;
         else if (k < 60) begin
            case ($urandom_range(0, 5))
               0: s = -1024;
               1: s = -1023;
               2: s = -1;
               3: s = 0;
               4: s = 1022;
               default: s = 1023;
            endcase
         end else s = int'($urandom_range(0, 2047)) - 1024;
         apply_settings(u, last, a, s);
         burst = $urandom_range(10, 50);
         // the stretch with no idling runs as one burst under one setting
         if (sent < 250 && sent + burst > 250) burst = 250 - sent;
         else if (sent >= 250 && sent < 400) burst = 400 - sent;
         repeat (burst) begin
            quiet = (sent >= 250 && sent < 400);
            send_date(random_date(), 1'b0, none);
            sent = sent + 1;
            maybe_idle(quiet);
         end
         phase = phase + 1;
      end

      wait_drained();
      repeat (12) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/amo_pkg.sv
rtl/amo_leap.sv
rtl/anchored_month_offset.sv
tb/sv/anchored_month_offset_tb.sv
